[sv/rscs_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package rscs_pkg;

   // geometry and statistic widths
   localparam int MAX_DIM  = 4096;
   localparam int CNT_W    = $clog2(MAX_DIM * MAX_DIM) + 1;
   localparam int SUM_W    = CNT_W + 7;    // 255 * count fits
   localparam int SQ_W     = CNT_W + 15;   // 65025 * count fits
   localparam int SQ_HALF  = SQ_W / 2;

   localparam int CFG_W    = 13;
   localparam int COORD_W  = 12;
   localparam int CHAN_W   = 8;
   localparam int CMD_W    = 2;
   localparam int NUM_CH   = 3;
   localparam int CH_IDX_W = 2;

   // shared multiplier and the exact variance test
   localparam int MUL_W    = 32;
   localparam int PROD_W   = 2 * MUL_W;
   localparam int NQ_W     = PROD_W + 1;
   localparam int LHS_W    = PROD_W + 4;   // 16 * d^2
   localparam int RHS_W    = NQ_W + 5;     // 25 * variance term

   localparam logic [CNT_W-1:0] SAMPLE_CAP = CNT_W'(MAX_DIM * MAX_DIM);

   // register indexes
   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_ROI_LEFT   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ROI_TOP    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ROI_RIGHT  = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_ROI_BOTTOM = 2'd3;

   // request command codes
   localparam logic [CMD_W-1:0] CMD_CLEAR    = 2'd0;
   localparam logic [CMD_W-1:0] CMD_ACCUM    = 2'd1;
   localparam logic [CMD_W-1:0] CMD_CLASSIFY = 2'd2;

   typedef enum logic [1:0] {
      OP_CLEAR    = 2'd0,
      OP_ACCUM    = 2'd1,
      OP_CLASSIFY = 2'd2
   } op_type;

   typedef struct packed {
      op_type                        op;
      logic [NUM_CH-1:0][CHAN_W-1:0] pix;   // 0 red, 1 green, 2 blue
   } op_entry_type;

   typedef struct packed {
      logic         valid;
      op_entry_type entry;
   } q_push_type;

   typedef struct packed {
      logic         valid;
      op_entry_type entry;
   } q_head_type;

endpackage

`default_nettype wire

[sv/rscs_req_if.sv]
`timescale 1ns / 1ps
`default_nettype none

interface rscs_req_if import rscs_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [CMD_W-1:0]   cmd;
   logic [COORD_W-1:0] pix_x;
   logic [COORD_W-1:0] pix_y;
   logic [CHAN_W-1:0]  red;
   logic [CHAN_W-1:0]  green;
   logic [CHAN_W-1:0]  blue;

   modport source (output valid, cmd, pix_x, pix_y, red, green, blue, input ready);
   modport sink   (input valid, cmd, pix_x, pix_y, red, green, blue, output ready);
endinterface

`default_nettype wire

[sv/rscs_rsp_if.sv]
`timescale 1ns / 1ps
`default_nettype none

interface rscs_rsp_if import rscs_pkg::*; ();
   logic valid;
   logic ready;
   logic mask;
   logic roi_empty;

   modport source (output valid, mask, roi_empty, input ready);
   modport sink   (input valid, mask, roi_empty, output ready);
endinterface

`default_nettype wire

[sv/rscs_front.sv]
`timescale 1ns / 1ps
`default_nettype none

module rscs_front import rscs_pkg::*; (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 csr_we,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [CFG_W-1:0]     csr_wdata,
   rscs_req_if.sink                  req,
   input  wire logic                 q_full,
   output q_push_type                push
);

   logic [CFG_W-1:0] left_ff, left_in;
   logic [CFG_W-1:0] top_ff, top_in;
   logic [CFG_W-1:0] right_ff, right_in;
   logic [CFG_W-1:0] bottom_ff, bottom_in;

   logic [CFG_W-1:0] px, py;
   logic             in_rect;
   logic             keep;
   op_type           op;

   always_comb begin
      left_in   = left_ff;
      top_in    = top_ff;
      right_in  = right_ff;
      bottom_in = bottom_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_ROI_LEFT:   left_in   = csr_wdata;
            CSR_ROI_TOP:    top_in    = csr_wdata;
            CSR_ROI_RIGHT:  right_in  = csr_wdata;
            CSR_ROI_BOTTOM: bottom_in = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         left_ff   <= '0;
         top_ff    <= '0;
         right_ff  <= '0;
         bottom_ff <= '0;
      end else begin
         left_ff   <= left_in;
         top_ff    <= top_in;
         right_ff  <= right_in;
         bottom_ff <= bottom_in;
      end
   end

   assign px = CFG_W'(req.pix_x);
   assign py = CFG_W'(req.pix_y);
   assign in_rect = (px >= left_ff) && (px < right_ff) && (py >= top_ff) && (py < bottom_ff);

   // beats that cannot touch state or give a result never enter the queue
   always_comb begin
      keep = 1'b0;
      op   = OP_CLEAR;
      case (req.cmd)
         CMD_CLEAR: begin
            keep = 1'b1;
            op   = OP_CLEAR;
         end
         CMD_ACCUM: begin
            keep = in_rect;
            op   = OP_ACCUM;
         end
         CMD_CLASSIFY: begin
            keep = 1'b1;
            op   = OP_CLASSIFY;
         end
         default: keep = 1'b0;
      endcase
   end

   assign req.ready        = !q_full;
   assign push.valid       = req.valid && !q_full && keep;
   assign push.entry.op    = op;
   assign push.entry.pix[0] = req.red;
   assign push.entry.pix[1] = req.green;
   assign push.entry.pix[2] = req.blue;

endmodule

`default_nettype wire

[sv/rscs_queue.sv]
`timescale 1ns / 1ps
`default_nettype none

module rscs_queue import rscs_pkg::*; #(
   parameter int DEPTH = 4
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire q_push_type push,
   output logic            full,
   input  wire logic       pop,
   output q_head_type      head
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W_Q = $clog2(DEPTH + 1);

   op_entry_type       mem_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W_Q-1:0] count_ff, count_in;
   logic               do_push, do_pop;

   assign full       = (count_ff == CNT_W_Q'(DEPTH));
   assign head.valid = (count_ff != '0);
   assign head.entry = mem_ff[rd_ptr_ff];

   assign do_push = push.valid && !full;
   assign do_pop  = pop && head.valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push.entry;
      end
   end

endmodule

`default_nettype wire

[sv/rscs_back.sv]
`timescale 1ns / 1ps
`default_nettype none

module rscs_back import rscs_pkg::*; (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire q_head_type head,
   output logic            pop,
   rscs_rsp_if.source      rsp
);

   typedef enum logic [9:0] {
      ST_IDLE = 10'b00_0000_0001,
      ST_NX   = 10'b00_0000_0010,
      ST_SS   = 10'b00_0000_0100,
      ST_NQL  = 10'b00_0000_1000,
      ST_NQH  = 10'b00_0001_0000,
      ST_DD   = 10'b00_0010_0000,
      ST_VAR  = 10'b00_0100_0000,
      ST_RHS  = 10'b00_1000_0000,
      ST_CMP  = 10'b01_0000_0000,
      ST_DONE = 10'b10_0000_0000
   } state_type;

   state_type state_ff, state_in;

   // statistics
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [SUM_W-1:0] sum_ff [NUM_CH];
   logic [SUM_W-1:0] sum_in [NUM_CH];
   logic [SQ_W-1:0]  sq_ff [NUM_CH];
   logic [SQ_W-1:0]  sq_in [NUM_CH];

   // classify sequencer
   logic [NUM_CH-1:0][CHAN_W-1:0] pix_ff, pix_in;
   logic [CH_IDX_W-1:0] chan_ff, chan_in;
   logic                ok_ff, ok_in;
   logic                empty_ff, empty_in;
   logic [PROD_W-1:0]   prod_ff, prod_in;
   logic [MUL_W-1:0]    mul_a, mul_b;
   logic [MUL_W-1:0]    d_ff, d_in;
   logic [PROD_W-1:0]   ss_ff, ss_in;
   logic [NQ_W-1:0]     nq_ff, nq_in;
   logic [PROD_W-1:0]   dd_ff, dd_in;
   logic [NQ_W-1:0]     v_ff, v_in;
   logic [RHS_W-1:0]    rhs_ff, rhs_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic                rsp_mask_ff, rsp_mask_in;
   logic                rsp_empty_ff, rsp_empty_in;

   logic [SUM_W-1:0]    sel_sum;
   logic [SQ_W-1:0]     sel_sq;
   logic [CHAN_W-1:0]   sel_pix;
   logic [SUM_W-1:0]    nx;
   logic [LHS_W-1:0]    lhs;

   assign sel_sum = sum_ff[chan_ff];
   assign sel_sq  = sq_ff[chan_ff];
   assign sel_pix = pix_ff[chan_ff];
   assign nx      = prod_ff[SUM_W-1:0];
   assign lhs     = {dd_ff, 4'b0000};

   // one shared multiplier, operands stepped per channel
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         ST_NX: begin
            mul_a = MUL_W'(cnt_ff);
            mul_b = MUL_W'(sel_pix);
         end
         ST_SS: begin
            mul_a = MUL_W'(sel_sum);
            mul_b = MUL_W'(sel_sum);
         end
         ST_NQL: begin
            mul_a = MUL_W'(cnt_ff);
            mul_b = MUL_W'(sel_sq[SQ_HALF-1:0]);
         end
         ST_NQH: begin
            mul_a = MUL_W'(cnt_ff);
            mul_b = MUL_W'(sel_sq[SQ_W-1:SQ_HALF]);
         end
         ST_DD: begin
            mul_a = d_ff;
            mul_b = d_ff;
         end
         default: ;
      endcase
   end

   assign prod_in = PROD_W'(mul_a) * PROD_W'(mul_b);

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      sum_in       = sum_ff;
      sq_in        = sq_ff;
      pix_in       = pix_ff;
      chan_in      = chan_ff;
      ok_in        = ok_ff;
      empty_in     = empty_ff;
      d_in         = d_ff;
      ss_in        = ss_ff;
      nq_in        = nq_ff;
      dd_in        = dd_ff;
      v_in         = v_ff;
      rhs_in       = rhs_ff;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      rsp_mask_in  = rsp_mask_ff;
      rsp_empty_in = rsp_empty_ff;
      pop          = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            pop = head.valid;
            if (head.valid) begin
               case (head.entry.op)
                  OP_CLEAR: begin
                     cnt_in = '0;
                     for (int i = 0; i < NUM_CH; i++) begin
                        sum_in[i] = '0;
                        sq_in[i]  = '0;
                     end
                  end
                  OP_ACCUM: begin
                     // count saturates, so the sums never wrap
                     if (cnt_ff < SAMPLE_CAP) begin
                        cnt_in = cnt_ff + 1'b1;
                        for (int i = 0; i < NUM_CH; i++) begin
                           sum_in[i] = sum_ff[i] + SUM_W'(head.entry.pix[i]);
                           sq_in[i]  = sq_ff[i] + SQ_W'({8'h00, head.entry.pix[i]} *
                                                        {8'h00, head.entry.pix[i]});
                        end
                     end
                  end
                  OP_CLASSIFY: begin
                     pix_in  = head.entry.pix;
                     chan_in = '0;
                     if (cnt_ff == '0) begin
                        ok_in    = 1'b0;
                        empty_in = 1'b1;
                        state_in = ST_DONE;
                     end else begin
                        ok_in    = 1'b1;
                        empty_in = 1'b0;
                        state_in = ST_NX;
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_NX:  state_in = ST_SS;
         ST_SS: begin
            d_in     = (nx >= sel_sum) ? nx - sel_sum : sel_sum - nx;
            state_in = ST_NQL;
         end
         ST_NQL: begin
            ss_in    = prod_ff;
            state_in = ST_NQH;
         end
         ST_NQH: begin
            nq_in    = NQ_W'(prod_ff);
            state_in = ST_DD;
         end
         ST_DD: begin
            nq_in    = nq_ff + (NQ_W'(prod_ff) << SQ_HALF);
            state_in = ST_VAR;
         end
         ST_VAR: begin
            dd_in    = prod_ff;
            v_in     = (nq_ff > NQ_W'(ss_ff)) ? nq_ff - NQ_W'(ss_ff) : '0;
            state_in = ST_RHS;
         end
         ST_RHS: begin
            rhs_in   = (RHS_W'(v_ff) << 4) + (RHS_W'(v_ff) << 3) + RHS_W'(v_ff);
            state_in = ST_CMP;
         end
         ST_CMP: begin
            ok_in = ok_ff && (RHS_W'(lhs) <= rhs_ff);
            if (chan_ff == CH_IDX_W'(NUM_CH - 1)) begin
               state_in = ST_DONE;
            end else begin
               chan_in  = chan_ff + 1'b1;
               state_in = ST_NX;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp.ready) begin
               rsp_valid_in = 1'b1;
               rsp_mask_in  = ok_ff;
               rsp_empty_in = empty_ff;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         cnt_ff       <= '0;
         for (int i = 0; i < NUM_CH; i++) begin
            sum_ff[i] <= '0;
            sq_ff[i]  <= '0;
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         cnt_ff       <= cnt_in;
         sum_ff       <= sum_in;
         sq_ff        <= sq_in;
      end
   end

   always_ff @(posedge clock) begin
      pix_ff       <= pix_in;
      chan_ff      <= chan_in;
      ok_ff        <= ok_in;
      empty_ff     <= empty_in;
      prod_ff      <= prod_in;
      d_ff         <= d_in;
      ss_ff        <= ss_in;
      nq_ff        <= nq_in;
      dd_ff        <= dd_in;
      v_ff         <= v_in;
      rhs_ff       <= rhs_in;
      rsp_mask_ff  <= rsp_mask_in;
      rsp_empty_ff <= rsp_empty_in;
   end

   assign rsp.valid     = rsp_valid_ff;
   assign rsp.mask      = rsp_mask_ff;
   assign rsp.roi_empty = rsp_empty_ff;

endmodule

`default_nettype wire

[sv/roi_stat_color_segmenter.sv]
`timescale 1ns / 1ps
`default_nettype none

// channel   dir  beat carries
// req_chan  in   cmd, pix_x, pix_y, red, green, blue
// rsp_chan  out  mask, roi_empty (one beat per classify)
// csr_*     in   roi_left/top/right/bottom, written by index
//
// Front takes a req beat each cycle the queue has room; the back drains the queue.
// Clear and accumulate finish in the back's idle state; classify steps one 32x32
// multiplier over the 3 channels, and skips it when the statistics are empty.
// Reset clears registers, statistics and queue at once; no sweep afterwards.
// A stalled rsp beat holds the next classify in its last cycle, and everything queued
// behind it; clears and accumulates ahead of that classify go on.

module roi_stat_color_segmenter import rscs_pkg::*; #(
   parameter int QUEUE_DEPTH = 4
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   rscs_req_if.sink                  req_chan,
   rscs_rsp_if.source                rsp_chan,
   input  wire logic                 csr_we,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [CFG_W-1:0]     csr_wdata
);

   q_push_type push;
   q_head_type head;
   logic       q_full;
   logic       pop;

   rscs_front u_front (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req       (req_chan),
      .q_full    (q_full),
      .push      (push)
   );

   rscs_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .full  (q_full),
      .pop   (pop),
      .head  (head)
   );

   rscs_back u_back (
      .clock (clock),
      .reset (reset),
      .head  (head),
      .pop   (pop),
      .rsp   (rsp_chan)
   );

endmodule

`default_nettype wire

[sv/rscs_checker.sv]
`timescale 1ns / 1ps
`default_nettype none

module rscs_checker (
   input wire logic clock,
   input wire logic reset,
   input wire logic rsp_valid,
   input wire logic rsp_ready,
   input wire logic rsp_mask,
   input wire logic rsp_roi_empty
);

   // a stalled beat stays up
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("rsp beat dropped while stalled");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_mask) && $stable(rsp_roi_empty))
      else $error("rsp payload changed while stalled");

   // empty statistics can never pass the color test
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_roi_empty |-> !rsp_mask)
      else $error("mask set with empty sample region");

   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp beat right after reset");

endmodule

bind roi_stat_color_segmenter rscs_checker u_rscs_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_chan.valid),
   .rsp_ready     (rsp_chan.ready),
   .rsp_mask      (rsp_chan.mask),
   .rsp_roi_empty (rsp_chan.roi_empty)
);

`default_nettype wire
